// ===== rtl/bdasc_pkg.sv =====
// Shared types, constants and the digit glyph table for the decimal/hex printer.
// Used by bdasc_cell and binary_to_decimal_ascii; depends on nothing else.
package bdasc_pkg;

    // Number of value bits that are converted.
    localparam int VALUE_BITS = 64;

    // Digits of 2**VALUE_BITS - 1 in decimal; hex never needs more.
    localparam int NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;

    // Widths of the controller counters.
    localparam int CNT_W = $clog2(NUM_DIGITS + 1);
    localparam int BIT_W = $clog2(VALUE_BITS);

    // Operation applied to every cell of the digit chain in the same cycle.
    typedef enum logic [1:0] {
        OP_HOLD  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_BIT   = 2'd2,
        OP_DIGIT = 2'd3
    } chain_op_t;

    // Control that the sequencer broadcasts to the cells.
    typedef struct packed {
        chain_op_t op;
        logic      dec;
    } cell_ctrl_t;

    // Input beat.
    typedef struct packed {
        logic [63:0] value;
        logic        mode;
    } in_beat_t;

    // Output beat.
    typedef struct packed {
        logic [6:0] digit_char;
        logic       last;
    } out_beat_t;

    // ASCII glyphs for digit values 0 through 15.
    localparam logic [6:0] GLYPHS [16] = '{
        7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
        7'h38, 7'h39, 7'h41, 7'h42, 7'h43, 7'h44, 7'h45, 7'h46
    };

endpackage

// ===== rtl/binary_to_decimal_ascii.sv =====
// Prints an unsigned value as ASCII decimal or upper-case hex digits, MSB first.
// The value is shifted into the digit chain bit by bit, then leading zero digits are skipped,
// then one beat is sent per digit; skipped and emitted digits always total NUM_DIGITS.
// One value at a time: the next is taken only once the sequencer is idle after the last beat.
// Output stalls delay the beats and the next value. The rate is set by the bit-serial shift.
// Reset (rst_n, asynchronous) returns the sequencer to idle; digits are not cleared.
module binary_to_decimal_ascii
    import bdasc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_beat_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_beat_t out_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_EMIT
    } state_t;

    state_t                  state_reg;
    logic [VALUE_BITS-1:0]   shift_reg;
    logic                    dec_reg;
    logic [BIT_W-1:0]        bit_cnt_reg;
    logic [CNT_W-1:0]        remain_reg;
    cell_ctrl_t              ctrl;
    logic                    carry [NUM_DIGITS];
    logic [3:0]              digits [NUM_DIGITS];
    logic [3:0]              top_digit;
    logic                    in_fire;
    logic                    out_fire;
    logic                    skip_more;

    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid && out_ready;
    assign top_digit = digits[NUM_DIGITS-1];
    assign skip_more = (top_digit == 4'd0) && (remain_reg != CNT_W'(1));

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_EMIT);
    assign out_data.digit_char = GLYPHS[top_digit];
    assign out_data.last       = (remain_reg == CNT_W'(1));

    // Chain operation for this cycle.
    always_comb
    begin
        ctrl.dec = dec_reg;
        case (state_reg)
            ST_IDLE: ctrl.op = in_fire ? OP_CLEAR : OP_HOLD;
            ST_CONV: ctrl.op = OP_BIT;
            ST_SKIP: ctrl.op = skip_more ? OP_DIGIT : OP_HOLD;
            ST_EMIT: ctrl.op = out_fire ? OP_DIGIT : OP_HOLD;
            default: ctrl.op = OP_HOLD;
        endcase
    end

    // Chain of digit cells; cell 0 is the least significant digit.
    genvar i;
    generate
        for (i = 0; i < NUM_DIGITS; i++)
        begin : g_cell
            if (i == 0)
            begin : g_first
                bdasc_cell u_cell (
                    .clk      (clk),
                    .ctrl     (ctrl),
                    .bit_in   (shift_reg[VALUE_BITS-1]),
                    .digit_in (4'd0),
                    .bit_out  (carry[i]),
                    .digit    (digits[i])
                );
            end
            else
            begin : g_rest
                bdasc_cell u_cell (
                    .clk      (clk),
                    .ctrl     (ctrl),
                    .bit_in   (carry[i-1]),
                    .digit_in (digits[i-1]),
                    .bit_out  (carry[i]),
                    .digit    (digits[i])
                );
            end
        end
    endgenerate

    // Sequencer: load, shift in bits, skip leading zeros, emit digits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            dec_reg     <= 1'b0;
            bit_cnt_reg <= '0;
            remain_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        dec_reg     <= ~in_data.mode;
                        bit_cnt_reg <= BIT_W'(VALUE_BITS - 1);
                        state_reg   <= ST_CONV;
                    end
                end
                ST_CONV:
                begin
                    bit_cnt_reg <= bit_cnt_reg - BIT_W'(1);
                    if (bit_cnt_reg == '0)
                    begin
                        remain_reg <= CNT_W'(NUM_DIGITS);
                        state_reg  <= ST_SKIP;
                    end
                end
                ST_SKIP:
                begin
                    if (skip_more)
                        remain_reg <= remain_reg - CNT_W'(1);
                    else
                        state_reg <= ST_EMIT;
                end
                ST_EMIT:
                begin
                    if (out_fire)
                    begin
                        remain_reg <= remain_reg - CNT_W'(1);
                        if (remain_reg == CNT_W'(1))
                            state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // Value bits feed the chain most significant first.
    always_ff @(posedge clk)
    begin
        if (in_fire)
            shift_reg <= in_data.value[VALUE_BITS-1:0];
        else if (state_reg == ST_CONV)
            shift_reg <= {shift_reg[VALUE_BITS-2:0], 1'b0};
    end

endmodule

// ===== rtl/bdasc_cell.sv =====
// One digit cell of the conversion chain: a 4-bit digit with add-3 correction in decimal mode.
// Depends on bdasc_pkg for the control struct and operation codes.
module bdasc_cell
    import bdasc_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  logic       bit_in,
    input  logic [3:0] digit_in,
    output logic       bit_out,
    output logic [3:0] digit
);

    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    logic [3:0] adj;

    // In decimal mode a digit of five or more is corrected before the shift.
    assign adj     = (ctrl.dec && (digit_reg > 4'd4)) ? digit_reg + 4'd3 : digit_reg;
    assign bit_out = adj[3];
    assign digit   = digit_reg;

    // Select the next digit value for the broadcast operation.
    always_comb
    begin
        case (ctrl.op)
            OP_CLEAR: digit_next = 4'd0;
            OP_BIT:   digit_next = {adj[2:0], bit_in};
            OP_DIGIT: digit_next = digit_in;
            default:  digit_next = digit_reg;
        endcase
    end

    // The digit is data only and needs no reset.
    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

endmodule
